// ===== rtl/mrcc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the mod-769 coefficient codec.
package mrcc_pkg;

  localparam int NSTG = 14;  // pipeline register stages
  localparam int QW   = 10;  // quotient width out of the reciprocal step

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  localparam logic [31:0] RECIP97 = 32'd43241;
  localparam logic [31:0] INV97   = 32'd1594008481;
  localparam logic [31:0] MUL48   = 32'd48;

  typedef struct packed {
    logic             func;
    logic [4:0][12:0] h;    // encode high parts
    logic [15:0]      lo;   // low bits (encode packed, decode raw)
    logic [31:0]      hv;
    logic [31:0]      zv;
    logic [QW-1:0]    qv;
    logic [4:0][15:0] co;
    logic [47:0]      po;
  } stg_t;

  typedef struct packed {
    logic [NSTG-1:0] load;
    logic [NSTG-1:0] vld;
  } pctl_t;

  function automatic logic [31:0] mul97(input logic [31:0] a);
    return (a << 6) + (a << 5) + a;
  endfunction

  // t*3 + l, t is the 14-bit top slice
  function automatic logic [31:0] fold3(input logic [13:0] t, input logic [18:0] l);
    return ({18'b0, t} << 1) + {18'b0, t} + {13'b0, l};
  endfunction

  // (z >> 9) * 27 + (z & 0x1FF)
  function automatic logic [31:0] fold27(input logic [31:0] z);
    logic [31:0] x;
    x = {9'b0, z[31:9]};
    return (x << 4) + (x << 3) + (x << 1) + x + {23'b0, z[8:0]};
  endfunction

  function automatic logic [QW-1:0] recip_q(input logic [31:0] z);
    logic [31:0] m;
    m = z * RECIP97;
    return m[31:32-QW];
  endfunction

  function automatic logic [15:0] coef_mk(input logic [31:0] z, input logic [2:0] l);
    return {z[12:0], 3'b000} + {13'b0, l};
  endfunction

endpackage

// ===== rtl/mixed_radix_coef_codec_q769_top.sv =====
// Top level of the five-coefficient mod-769 pack/unpack codec.
// out_valid is registered: an accepted item moves through stage registers 0 to 13, and an output stall holds it.
// Throughput: one item per cycle while the output is not stalled; the decode chain of remainder and
// inverse-multiply steps is cut into 14 register stages.
// Bubbles close up under stall; a stage loads when the output is not stalled or any stage at or after it is empty.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
module mixed_radix_coef_codec_q769_top import mrcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] coef_in_0,
  input  logic [15:0] coef_in_1,
  input  logic [15:0] coef_in_2,
  input  logic [15:0] coef_in_3,
  input  logic [15:0] coef_in_4,
  input  logic [47:0] packed_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] coef_out_0,
  output logic [15:0] coef_out_1,
  output logic [15:0] coef_out_2,
  output logic [15:0] coef_out_3,
  output logic [15:0] coef_out_4,
  output logic [47:0] packed_out
);

  pctl_t ctl;
  stg_t  res;

  mrcc_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctl       (ctl)
  );

  mrcc_dp u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .func      (func),
    .coef_in_0 (coef_in_0),
    .coef_in_1 (coef_in_1),
    .coef_in_2 (coef_in_2),
    .coef_in_3 (coef_in_3),
    .coef_in_4 (coef_in_4),
    .packed_in (packed_in),
    .res       (res)
  );

  assign out_valid  = ctl.vld[NSTG-1];
  assign coef_out_0 = res.co[0];
  assign coef_out_1 = res.co[1];
  assign coef_out_2 = res.co[2];
  assign coef_out_3 = res.co[3];
  assign coef_out_4 = res.co[4];
  assign packed_out = res.po;

endmodule

// ===== rtl/mrcc_ctl.sv =====
// Valid bits and per-stage load enables for the codec pipeline.
module mrcc_ctl import mrcc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_stall,
  output logic  in_stall,
  output pctl_t ctl
);

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // a stage may load if any stage at or after it is empty, or the output moves
  for (genvar g = 0; g < NSTG; g++) begin : g_adv
    assign adv[g] = !out_stall || !(&vld[NSTG-1:g]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_stall = !adv[0];
  assign ctl.load = adv;
  assign ctl.vld  = vld;

endmodule

// ===== rtl/mrcc_dp.sv =====
// Datapath registers and per-stage encode/decode arithmetic.
module mrcc_dp import mrcc_pkg::*; (
  input  logic        clk,
  input  pctl_t       ctl,
  input  logic        func,
  input  logic [15:0] coef_in_0,
  input  logic [15:0] coef_in_1,
  input  logic [15:0] coef_in_2,
  input  logic [15:0] coef_in_3,
  input  logic [15:0] coef_in_4,
  input  logic [47:0] packed_in,
  output stg_t        res
);

  stg_t s   [NSTG];
  stg_t nxt [NSTG];

  always_comb begin
    logic [31:0] m48;
    logic [31:0] sum;
    logic [31:0] z;

    z = '0;

    // stage 0: split input, first Horner step / first fold
    nxt[0]      = '0;
    nxt[0].func = func;
    if (func == FUNC_ENC) begin
      nxt[0].h  = {coef_in_4[15:3], coef_in_3[15:3], coef_in_2[15:3],
                   coef_in_1[15:3], coef_in_0[15:3]};
      nxt[0].lo = {coef_in_4[2:0], coef_in_3[2:0], coef_in_2[2:0],
                   coef_in_1[2:0], coef_in_0[2:0], 1'b0};
      nxt[0].hv = mul97({19'b0, coef_in_4[15:3]}) + {19'b0, coef_in_3[15:3]};
    end else begin
      nxt[0].lo = packed_in[15:0];
      nxt[0].hv = packed_in[47:16];
      nxt[0].zv = fold27(fold3({packed_in[0], packed_in[47:35]}, packed_in[34:16]));
    end

    // stage 1
    nxt[1] = s[0];
    if (s[0].func == FUNC_ENC) nxt[1].hv = mul97(s[0].hv) + {19'b0, s[0].h[2]};
    else                       nxt[1].qv = recip_q(s[0].zv);

    // stage 2: encode Horner step; decode coefficient 0 remainder
    nxt[2] = s[1];
    if (s[1].func == FUNC_ENC) begin
      nxt[2].hv = mul97(s[1].hv) + {19'b0, s[1].h[1]};
    end else begin
      z            = s[1].zv - mul97({{(32-QW){1'b0}}, s[1].qv});
      nxt[2].zv    = z;
      nxt[2].co[0] = coef_mk(z, s[1].lo[3:1]);
      nxt[2].hv    = s[1].hv - z;
    end

    // stage 3: encode takes 96*H and the first carry; decode multiplies by INV97
    nxt[3] = s[2];
    m48    = s[2].hv * MUL48;
    if (s[2].func == FUNC_ENC) begin
      nxt[3].lo[0] = s[2].lo[0] | m48[31];
      nxt[3].zv    = m48 << 1;
      nxt[3].hv    = s[2].hv + {19'b0, s[2].h[0]};
    end else begin
      nxt[3].hv = s[2].hv * INV97;
    end

    // stage 4: encode finishes; decode folds the product
    nxt[4] = s[3];
    sum    = s[3].zv + s[3].hv;
    if (s[3].func == FUNC_ENC) begin
      nxt[4].po = {sum, s[3].lo[15:1], s[3].lo[0] | (s[3].zv[31] & ~sum[31])};
    end else begin
      nxt[4].zv = fold27(fold3({1'b0, s[3].hv[31:19]}, s[3].hv[18:0]));
    end

    nxt[5] = s[4];
    if (s[4].func == FUNC_DEC) nxt[5].qv = recip_q(s[4].zv);

    nxt[6] = s[5];
    if (s[5].func == FUNC_DEC) begin
      z            = s[5].zv - mul97({{(32-QW){1'b0}}, s[5].qv});
      nxt[6].zv    = z;
      nxt[6].co[1] = coef_mk(z, s[5].lo[6:4]);
      nxt[6].hv    = s[5].hv - z;
    end

    nxt[7] = s[6];
    if (s[6].func == FUNC_DEC) nxt[7].hv = s[6].hv * INV97;

    nxt[8] = s[7];
    if (s[7].func == FUNC_DEC) nxt[8].zv = fold27(s[7].hv);

    nxt[9] = s[8];
    if (s[8].func == FUNC_DEC) nxt[9].qv = recip_q(s[8].zv);

    nxt[10] = s[9];
    if (s[9].func == FUNC_DEC) begin
      z             = s[9].zv - mul97({{(32-QW){1'b0}}, s[9].qv});
      nxt[10].zv    = z;
      nxt[10].co[2] = coef_mk(z, s[9].lo[9:7]);
      nxt[10].hv    = s[9].hv - z;
    end

    nxt[11] = s[10];
    if (s[10].func == FUNC_DEC) nxt[11].hv = s[10].hv * INV97;

    // full 32-bit value here, the reciprocal product wraps
    nxt[12] = s[11];
    if (s[11].func == FUNC_DEC) nxt[12].qv = recip_q(s[11].hv);

    nxt[13] = s[12];
    if (s[12].func == FUNC_DEC) begin
      z             = s[12].hv - mul97({{(32-QW){1'b0}}, s[12].qv});
      nxt[13].zv    = z;
      nxt[13].co[3] = coef_mk(z, s[12].lo[12:10]);
      nxt[13].co[4] = {{(13-QW){1'b0}}, s[12].qv, 3'b000} + {13'b0, s[12].lo[15:13]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (ctl.load[k]) s[k] <= nxt[k];
    end
  end

  assign res = s[NSTG-1];

endmodule

// ===== rtl/mrcc_chk.sv =====
// Port-level checker for the codec top level, with its bind.
module mrcc_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] coef_out_0,
  input logic [15:0] coef_out_1,
  input logic [15:0] coef_out_2,
  input logic [15:0] coef_out_3,
  input logic [15:0] coef_out_4,
  input logic [47:0] packed_out
);

  // input only backs up when the whole pipe is full behind a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output item dropped while stalled");

  // an item carries either the packed word or the coefficients, never both
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((packed_out == 48'd0) ||
                   (coef_out_0 == 16'd0 && coef_out_1 == 16'd0 &&
                    coef_out_2 == 16'd0 && coef_out_3 == 16'd0 &&
                    coef_out_4 == 16'd0)))
    else $error("both result sides nonzero");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("out_valid right after reset");

endmodule

bind mixed_radix_coef_codec_q769_top mrcc_chk u_chk (.*);
